// File: hdl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg
// shared types and constants of the max weight closure flow solver
// ----------------------------------------------------------------------------
package mwc_pkg;

  localparam int unsigned MAX_NODES_DEF   = 64;
  localparam int unsigned MAX_DEPS_DEF    = 256;
  localparam int unsigned WEIGHT_BITS_DEF = 21;

  localparam int unsigned NODE_BITS  = 7;
  localparam int unsigned OUT_BITS   = 26;
  localparam int unsigned CAP_BITS   = 30;
  localparam int unsigned FLOW_BITS  = 31;
  localparam int unsigned RES_BITS   = 32;
  localparam int unsigned DEP_CAP    = 1000000000;

  typedef enum logic [1:0] {
    ACT_SET_WEIGHT = 2'd0,
    ACT_ADD_EDGE   = 2'd1,
    ACT_SOLVE      = 2'd2,
    ACT_UNUSED     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_NODES = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

endpackage

// File: hdl/mwc_if.sv
// ----------------------------------------------------------------------------
// mwc_in_if / mwc_out_if
// valid/ready channels for load and solve beats and for solve results
// ----------------------------------------------------------------------------
interface mwc_in_if #(
  parameter int unsigned WEIGHT_BITS = 21
) ();
  import mwc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [NODE_BITS-1:0]          dependent_node;
  logic [NODE_BITS-1:0]          required_node;
  logic signed [WEIGHT_BITS-1:0] node_weight_value;

  modport source (output valid, action, dependent_node, required_node,
                  node_weight_value, input ready);
  modport sink   (input valid, action, dependent_node, required_node,
                  node_weight_value, output ready);
endinterface

interface mwc_out_if ();
  import mwc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] closure_weight;
  logic [OUT_BITS-1:0] flow_value;
  logic [1:0]          status;

  modport source (output valid, closure_weight, flow_value, status, input ready);
  modport sink   (input valid, closure_weight, flow_value, status, output ready);
endinterface

// File: hdl/mwc_ram.sv
// ----------------------------------------------------------------------------
// mwc_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module mwc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned ABITS = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ABITS-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [ABITS-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/max_weight_closure_maxflow_unit.sv
// ----------------------------------------------------------------------------
// max_weight_closure_maxflow_unit
// maximum weight closure by dinic max flow over memory-held graph
// ----------------------------------------------------------------------------
// usage:
//   in_i carries beats: set weight and add edge beats load the weight and
//   arc memories, a solve beat builds the source/sink network, runs the
//   flow search and returns one beat on out_o. cfg_we_i/cfg_wdata_i set the
//   node count, only while the block is idle: the user must keep to this,
//   the block itself does not enforce it. a set weight beat is written
//   directly, an add edge beat reads and updates the first-arc memory for
//   both ends. a solve first builds the network, a source arc for each node
//   of positive weight and a sink arc for each other node, then runs phases
//   of levelling and path search with retreats, augmenting each path found.
//   reset clears the weight and first-arc valid bits, the arc count, the
//   overflow flag and the node count; no clearing pass is needed. after a
//   solve the valid bits, arc count and overflow flag are cleared the same way.
//   a result waits in the output register while out_o is stalled; load
//   beats are still taken, a following solve holds at its end until the
//   output register is free.
// ----------------------------------------------------------------------------
module max_weight_closure_maxflow_unit #(
  parameter int unsigned MAX_NODES   = mwc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEPS    = mwc_pkg::MAX_DEPS_DEF,
  parameter int unsigned WEIGHT_BITS = mwc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwc_pkg::NODE_BITS-1:0] cfg_wdata_i,
  mwc_in_if.sink                        in_i,
  mwc_out_if.source                     out_o
);

  import mwc_pkg::*;

  localparam int unsigned NODE_SLOTS = MAX_NODES + 2;
  localparam int unsigned ARC_DEPTH  = 2 * MAX_DEPS + 2 * MAX_NODES;
  localparam int unsigned NW   = $clog2(NODE_SLOTS);
  localparam int unsigned CW   = $clog2(NODE_SLOTS + 1);
  localparam int unsigned AW   = $clog2(ARC_DEPTH + 1);
  localparam int unsigned ARB  = $clog2(ARC_DEPTH);
  localparam int unsigned SW   = WEIGHT_BITS + NW + 1;
  localparam int unsigned ARCW = NW + CAP_BITS + FLOW_BITS + AW;
  localparam int unsigned FLO  = AW;
  localparam int unsigned CPO  = AW + FLOW_BITS;
  localparam int unsigned TGO  = AW + FLOW_BITS + CAP_BITS;

  localparam logic [AW-1:0] NO_ARC   = AW'(ARC_DEPTH);
  localparam logic [AW-1:0] EDGE_LIM = AW'(2 * MAX_DEPS);
  localparam logic [NW-1:0] SNK      = NW'(MAX_NODES + 1);
  localparam logic [NW-1:0] SRC      = '0;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_A_RD  = 5'd1;
  localparam logic [4:0] S_A_W1  = 5'd2;
  localparam logic [4:0] S_A_W2  = 5'd3;
  localparam logic [4:0] S_B_RD  = 5'd4;
  localparam logic [4:0] S_B_W   = 5'd5;
  localparam logic [4:0] S_Q_INI = 5'd6;
  localparam logic [4:0] S_Q_POP = 5'd7;
  localparam logic [4:0] S_Q_X   = 5'd8;
  localparam logic [4:0] S_Q_ARC = 5'd9;
  localparam logic [4:0] S_Q_CHK = 5'd10;
  localparam logic [4:0] S_D_TOP = 5'd11;
  localparam logic [4:0] S_D_CUR = 5'd12;
  localparam logic [4:0] S_D_SCN = 5'd13;
  localparam logic [4:0] S_D_LVL = 5'd14;
  localparam logic [4:0] S_D_RET = 5'd15;
  localparam logic [4:0] S_D_POP = 5'd16;
  localparam logic [4:0] S_D_PT  = 5'd17;
  localparam logic [4:0] S_D_AD1 = 5'd18;
  localparam logic [4:0] S_D_AD2 = 5'd19;
  localparam logic [4:0] S_G_RD  = 5'd20;
  localparam logic [4:0] S_G_ARC = 5'd21;
  localparam logic [4:0] S_G_MIN = 5'd22;
  localparam logic [4:0] S_U_RD  = 5'd23;
  localparam logic [4:0] S_U_A   = 5'd24;
  localparam logic [4:0] S_U_W   = 5'd25;
  localparam logic [4:0] S_U_W2  = 5'd26;
  localparam logic [4:0] S_FIN   = 5'd27;

  logic [4:0] st_q, st_d;
  logic [NODE_BITS-1:0] ncnt_q;
  logic [NW-1:0] n_q, n_d, v_q, v_d, lx_q, lx_d, au_q, au_d, av_q, av_d;
  logic [CW-1:0] i_q, i_d, head_q, head_d, tail_q, tail_d, dep_q, dep_d;
  logic [AW-1:0] a_q, a_d, acnt_q, acnt_d;
  logic [CAP_BITS-1:0] acap_q, acap_d;
  logic aret_q, aret_d, ovf_q, ovf_d;
  logic [SW-1:0] sum_q, sum_d, flow_q, flow_d, tot_q, tot_d;
  logic signed [RES_BITS-1:0] b_q, b_d;
  logic [NODE_SLOTS-1:0] wt_vld_q, wt_vld_d, fa_vld_q, fa_vld_d;
  logic [NODE_SLOTS-1:0] vis_q, vis_d, cv_q, cv_d;
  logic wt_hit_q, fa_hit_q, cv_hit_q;
  logic out_vld_q, out_ld;
  logic [OUT_BITS-1:0] out_cw_q, out_fv_q;
  logic [1:0] out_st_q;

  logic wt_we, wt_re, fa_we, fa_re, lvl_we, lvl_re, cur_we, cur_re;
  logic que_we, que_re, stk_we, stk_re, arc_we, arc_re;
  logic [NW-1:0] wt_wa, wt_ra, fa_wa, fa_ra, lvl_wa, lvl_ra, cur_wa, cur_ra;
  logic [NW-1:0] que_wa, que_ra, stk_wa, stk_ra;
  logic [ARB-1:0] arc_wa, arc_ra;
  logic signed [WEIGHT_BITS-1:0] wt_wd, wt_rd;
  logic [AW-1:0] fa_wd, fa_rd, cur_wd, cur_rd, stk_wd, stk_rd;
  logic [NW-1:0] lvl_wd, lvl_rd, que_wd, que_rd;
  logic [ARCW-1:0] arc_wd, arc_rd;

  logic [NW-1:0] arc_t, u_n, v_n, n_in;
  logic [CAP_BITS-1:0] arc_cap;
  logic [FLOW_BITS-1:0] arc_fl;
  logic [AW-1:0] arc_nx, fa_sel, cur_sel, nxt_a;
  logic signed [RES_BITS-1:0] capx, flx, res;
  logic signed [RES_BITS-1:0] wx, wneg;
  logic signed [WEIGHT_BITS-1:0] w_cur;
  logic t_ok, u_ok, v_ok, in_acc;

  assign arc_nx  = arc_rd[AW-1:0];
  assign arc_fl  = arc_rd[FLO +: FLOW_BITS];
  assign arc_cap = arc_rd[CPO +: CAP_BITS];
  assign arc_t   = arc_rd[TGO +: NW];
  assign capx    = $signed({{(RES_BITS - CAP_BITS){1'b0}}, arc_cap});
  assign flx     = $signed({{(RES_BITS - FLOW_BITS){arc_fl[FLOW_BITS-1]}}, arc_fl});
  assign res     = capx - flx;
  assign t_ok    = (arc_t <= n_q) || (arc_t == SNK);
  assign fa_sel  = fa_hit_q ? fa_rd : NO_ARC;
  assign cur_sel = cv_hit_q ? cur_rd : fa_sel;
  assign w_cur   = wt_hit_q ? wt_rd : '0;
  assign wx      = RES_BITS'(w_cur);
  assign wneg    = -wx;

  assign u_ok = (in_i.dependent_node != '0) && (32'(in_i.dependent_node) <= MAX_NODES);
  assign v_ok = (in_i.required_node != '0) && (32'(in_i.required_node) <= MAX_NODES);
  assign u_n  = NW'(in_i.dependent_node);
  assign v_n  = NW'(in_i.required_node);
  assign n_in = (32'(ncnt_q) > MAX_NODES) ? NW'(MAX_NODES) : NW'(ncnt_q);
  assign nxt_a = (au_q == av_q) ? acnt_q : fa_sel;

  assign in_i.ready = (st_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    st_d = st_q; n_d = n_q; v_d = v_q; lx_d = lx_q; au_d = au_q; av_d = av_q;
    i_d = i_q; head_d = head_q; tail_d = tail_q; dep_d = dep_q; a_d = a_q;
    acnt_d = acnt_q; acap_d = acap_q; aret_d = aret_q; ovf_d = ovf_q;
    sum_d = sum_q; flow_d = flow_q; tot_d = tot_q; b_d = b_q;
    wt_vld_d = wt_vld_q; fa_vld_d = fa_vld_q; vis_d = vis_q; cv_d = cv_q;
    out_ld = 1'b0;
    wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_re = 1'b0; wt_ra = '0;
    fa_we = 1'b0; fa_wa = '0; fa_wd = '0; fa_re = 1'b0; fa_ra = '0;
    lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_re = 1'b0; lvl_ra = '0;
    cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_re = 1'b0; cur_ra = '0;
    que_we = 1'b0; que_wa = '0; que_wd = '0; que_re = 1'b0; que_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
    arc_we = 1'b0; arc_wa = '0; arc_wd = '0; arc_re = 1'b0; arc_ra = '0;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(in_i.action))
            ACT_SET_WEIGHT: begin
              if (u_ok) begin
                wt_we = 1'b1; wt_wa = u_n; wt_wd = in_i.node_weight_value;
                wt_vld_d[u_n] = 1'b1;
              end
            end
            ACT_ADD_EDGE: begin
              if (u_ok && v_ok) begin
                if (acnt_q >= EDGE_LIM) begin
                  ovf_d = 1'b1;
                end else begin
                  au_d = u_n; av_d = v_n; acap_d = CAP_BITS'(DEP_CAP);
                  aret_d = 1'b0; st_d = S_A_RD;
                end
              end
            end
            ACT_SOLVE: begin
              n_d = n_in; sum_d = '0; flow_d = '0; i_d = CW'(1);
              st_d = (n_in == '0) ? S_FIN : S_B_RD;
            end
            default: ;
          endcase
        end
      end
      S_A_RD: begin
        fa_re = 1'b1; fa_ra = au_q; st_d = S_A_W1;
      end
      S_A_W1: begin
        arc_we = 1'b1; arc_wa = acnt_q[ARB-1:0];
        arc_wd = {av_q, acap_q, {FLOW_BITS{1'b0}}, fa_sel};
        fa_we = 1'b1; fa_wa = au_q; fa_wd = acnt_q; fa_vld_d[au_q] = 1'b1;
        fa_re = 1'b1; fa_ra = av_q; st_d = S_A_W2;
      end
      S_A_W2: begin
        arc_we = 1'b1; arc_wa = ARB'(acnt_q + 1'b1);
        arc_wd = {au_q, {CAP_BITS{1'b0}}, {FLOW_BITS{1'b0}}, nxt_a};
        fa_we = 1'b1; fa_wa = av_q; fa_wd = AW'(acnt_q + 1'b1);
        fa_vld_d[av_q] = 1'b1;
        acnt_d = AW'(acnt_q + 2'd2);
        if (!aret_q) begin
          st_d = S_IDLE;
        end else if (i_q == CW'(n_q)) begin
          st_d = S_Q_INI;
        end else begin
          i_d = CW'(i_q + 1'b1); st_d = S_B_RD;
        end
      end
      S_B_RD: begin
        wt_re = 1'b1; wt_ra = i_q[NW-1:0]; st_d = S_B_W;
      end
      S_B_W: begin
        if (w_cur > 0) begin
          au_d = SRC; av_d = i_q[NW-1:0]; acap_d = wx[CAP_BITS-1:0];
          sum_d = SW'(sum_q + SW'(wx[WEIGHT_BITS-1:0]));
        end else begin
          au_d = i_q[NW-1:0]; av_d = SNK; acap_d = wneg[CAP_BITS-1:0];
        end
        aret_d = 1'b1; st_d = S_A_RD;
      end
      S_Q_INI: begin
        vis_d = '0; vis_d[SRC] = 1'b1;
        lvl_we = 1'b1; lvl_wa = SRC; lvl_wd = '0;
        que_we = 1'b1; que_wa = '0; que_wd = SRC;
        head_d = '0; tail_d = CW'(1); st_d = S_Q_POP;
      end
      S_Q_POP: begin
        if (head_q < tail_q) begin
          que_re = 1'b1; que_ra = head_q[NW-1:0];
          head_d = CW'(head_q + 1'b1); st_d = S_Q_X;
        end else if (vis_q[SNK]) begin
          cv_d = '0; dep_d = '0; v_d = SRC; tot_d = '0; st_d = S_D_TOP;
        end else begin
          st_d = S_FIN;
        end
      end
      S_Q_X: begin
        v_d = que_rd;
        lvl_re = 1'b1; lvl_ra = que_rd; fa_re = 1'b1; fa_ra = que_rd;
        st_d = S_Q_ARC;
      end
      S_Q_ARC: begin
        lx_d = lvl_rd;
        if (fa_sel == NO_ARC) begin
          st_d = S_Q_POP;
        end else begin
          arc_re = 1'b1; arc_ra = fa_sel[ARB-1:0]; st_d = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (t_ok && !vis_q[arc_t] && (capx > flx)) begin
          vis_d[arc_t] = 1'b1;
          lvl_we = 1'b1; lvl_wa = arc_t; lvl_wd = NW'(lx_q + 1'b1);
          if (32'(tail_q) < NODE_SLOTS) begin
            que_we = 1'b1; que_wa = tail_q[NW-1:0]; que_wd = arc_t;
            tail_d = CW'(tail_q + 1'b1);
          end
        end
        if (arc_nx == NO_ARC) begin
          st_d = S_Q_POP;
        end else begin
          arc_re = 1'b1; arc_ra = arc_nx[ARB-1:0];
        end
      end
      S_D_TOP: begin
        if (v_q == SNK) begin
          i_d = '0; b_d = {1'b0, {(RES_BITS - 1){1'b1}}}; st_d = S_G_RD;
        end else begin
          cur_re = 1'b1; cur_ra = v_q; fa_re = 1'b1; fa_ra = v_q;
          lvl_re = 1'b1; lvl_ra = v_q; st_d = S_D_CUR;
        end
      end
      S_D_CUR: begin
        lx_d = lvl_rd; a_d = cur_sel;
        if (cur_sel == NO_ARC) begin
          cur_we = 1'b1; cur_wa = v_q; cur_wd = NO_ARC; cv_d[v_q] = 1'b1;
          st_d = S_D_RET;
        end else begin
          arc_re = 1'b1; arc_ra = cur_sel[ARB-1:0]; st_d = S_D_SCN;
        end
      end
      S_D_SCN: begin
        lvl_re = 1'b1; lvl_ra = arc_t; st_d = S_D_LVL;
      end
      S_D_LVL: begin
        if (t_ok && vis_q[arc_t] && (capx > flx) && (lvl_rd == NW'(lx_q + 1'b1))) begin
          cur_we = 1'b1; cur_wa = v_q; cur_wd = a_q; cv_d[v_q] = 1'b1;
          if (32'(dep_q) < NODE_SLOTS) begin
            stk_we = 1'b1; stk_wa = dep_q[NW-1:0]; stk_wd = a_q;
            dep_d = CW'(dep_q + 1'b1); v_d = arc_t; st_d = S_D_TOP;
          end else begin
            st_d = S_D_RET;
          end
        end else if (arc_nx == NO_ARC) begin
          cur_we = 1'b1; cur_wa = v_q; cur_wd = NO_ARC; cv_d[v_q] = 1'b1;
          st_d = S_D_RET;
        end else begin
          a_d = arc_nx; arc_re = 1'b1; arc_ra = arc_nx[ARB-1:0]; st_d = S_D_SCN;
        end
      end
      S_D_RET: begin
        if (dep_q == '0) begin
          flow_d = SW'(flow_q + tot_q); st_d = S_Q_INI;
        end else begin
          dep_d = CW'(dep_q - 1'b1);
          stk_re = 1'b1; stk_ra = NW'(dep_q - 1'b1); st_d = S_D_POP;
        end
      end
      S_D_POP: begin
        arc_re = 1'b1; arc_ra = ARB'(stk_rd ^ AW'(1)); st_d = S_D_PT;
      end
      S_D_PT: begin
        v_d = arc_t;
        cur_re = 1'b1; cur_ra = arc_t; fa_re = 1'b1; fa_ra = arc_t;
        st_d = S_D_AD1;
      end
      S_D_AD1: begin
        if (cur_sel == NO_ARC) begin
          st_d = S_D_TOP;
        end else begin
          arc_re = 1'b1; arc_ra = cur_sel[ARB-1:0]; st_d = S_D_AD2;
        end
      end
      S_D_AD2: begin
        cur_we = 1'b1; cur_wa = v_q; cur_wd = arc_nx; cv_d[v_q] = 1'b1;
        st_d = S_D_TOP;
      end
      S_G_RD: begin
        if (i_q < dep_q) begin
          stk_re = 1'b1; stk_ra = i_q[NW-1:0]; st_d = S_G_ARC;
        end else begin
          i_d = '0; st_d = S_U_RD;
        end
      end
      S_G_ARC: begin
        arc_re = 1'b1; arc_ra = stk_rd[ARB-1:0]; st_d = S_G_MIN;
      end
      S_G_MIN: begin
        if (res < b_q) begin
          b_d = res;
        end
        i_d = CW'(i_q + 1'b1); st_d = S_G_RD;
      end
      S_U_RD: begin
        if (i_q < dep_q) begin
          stk_re = 1'b1; stk_ra = i_q[NW-1:0]; st_d = S_U_A;
        end else begin
          tot_d = SW'(tot_q + SW'(b_q[FLOW_BITS-1:0]));
          dep_d = '0; v_d = SRC; st_d = S_D_TOP;
        end
      end
      S_U_A: begin
        a_d = stk_rd; arc_re = 1'b1; arc_ra = stk_rd[ARB-1:0]; st_d = S_U_W;
      end
      S_U_W: begin
        arc_we = 1'b1; arc_wa = a_q[ARB-1:0];
        arc_wd = {arc_rd[ARCW-1:CPO], FLOW_BITS'(flx + b_q), arc_nx};
        arc_re = 1'b1; arc_ra = ARB'(a_q ^ AW'(1)); st_d = S_U_W2;
      end
      S_U_W2: begin
        arc_we = 1'b1; arc_wa = ARB'(a_q ^ AW'(1));
        arc_wd = {arc_rd[ARCW-1:CPO], FLOW_BITS'(flx - b_q), arc_nx};
        i_d = CW'(i_q + 1'b1); st_d = S_U_RD;
      end
      S_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_ld = 1'b1;
          wt_vld_d = '0; fa_vld_d = '0; acnt_d = '0; ovf_d = 1'b0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ncnt_q <= '0; n_q <= '0; v_q <= '0; lx_q <= '0;
      au_q <= '0; av_q <= '0; i_q <= '0; head_q <= '0; tail_q <= '0;
      dep_q <= '0; a_q <= '0; acnt_q <= '0; acap_q <= '0; aret_q <= 1'b0;
      ovf_q <= 1'b0; sum_q <= '0; flow_q <= '0; tot_q <= '0; b_q <= '0;
      wt_vld_q <= '0; fa_vld_q <= '0; vis_q <= '0; cv_q <= '0;
      wt_hit_q <= 1'b0; fa_hit_q <= 1'b0; cv_hit_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; v_q <= v_d; lx_q <= lx_d;
      au_q <= au_d; av_q <= av_d; i_q <= i_d; head_q <= head_d; tail_q <= tail_d;
      dep_q <= dep_d; a_q <= a_d; acnt_q <= acnt_d; acap_q <= acap_d;
      aret_q <= aret_d; ovf_q <= ovf_d; sum_q <= sum_d; flow_q <= flow_d;
      tot_q <= tot_d; b_q <= b_d;
      wt_vld_q <= wt_vld_d; fa_vld_q <= fa_vld_d; vis_q <= vis_d; cv_q <= cv_d;
      if (cfg_we_i) begin
        ncnt_q <= cfg_wdata_i;
      end
      if (wt_re) begin
        wt_hit_q <= wt_vld_q[wt_ra];
      end
      if (fa_re) begin
        fa_hit_q <= fa_vld_q[fa_ra];
      end
      if (cur_re) begin
        cv_hit_q <= cv_q[cur_ra];
      end
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_cw_q <= OUT_BITS'(SW'(sum_q - flow_q));
      out_fv_q <= OUT_BITS'(flow_q);
      if (n_q == '0) begin
        out_st_q <= ST_NO_NODES;
      end else if (ovf_q) begin
        out_st_q <= ST_OVERFLOW;
      end else begin
        out_st_q <= ST_OK;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.closure_weight = out_cw_q;
  assign out_o.flow_value     = out_fv_q;
  assign out_o.status         = out_st_q;

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(WEIGHT_BITS)) u_wt (
    .clk_i, .we_i(wt_we), .waddr_i(wt_wa), .wdata_i(wt_wd),
    .re_i(wt_re), .raddr_i(wt_ra), .rdata_o(wt_rd)
  );

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(AW)) u_fa (
    .clk_i, .we_i(fa_we), .waddr_i(fa_wa), .wdata_i(fa_wd),
    .re_i(fa_re), .raddr_i(fa_ra), .rdata_o(fa_rd)
  );

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(NW)) u_lvl (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_wa), .wdata_i(lvl_wd),
    .re_i(lvl_re), .raddr_i(lvl_ra), .rdata_o(lvl_rd)
  );

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(AW)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_wa), .wdata_i(cur_wd),
    .re_i(cur_re), .raddr_i(cur_ra), .rdata_o(cur_rd)
  );

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(NW)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_wa), .wdata_i(que_wd),
    .re_i(que_re), .raddr_i(que_ra), .rdata_o(que_rd)
  );

  mwc_ram #(.DEPTH(NODE_SLOTS), .WIDTH(AW)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  mwc_ram #(.DEPTH(ARC_DEPTH), .WIDTH(ARCW)) u_arc (
    .clk_i, .we_i(arc_we), .waddr_i(arc_wa), .wdata_i(arc_wd),
    .re_i(arc_re), .raddr_i(arc_ra), .rdata_o(arc_rd)
  );

endmodule
